FILE: hdl/idll_pkg.sv
// ----------------------------------------------------------------------------
// idll_pkg
// Types, constants and helpers for the indexed doubly linked list.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int DATA_BITS = 32;           // stored data word
  localparam int SLOT_W    = 11;           // signed slot number, -1 is none
  localparam int COUNT_W   = 11;
  localparam int VALUE_W   = 32;
  localparam int DATA_W    = 32;           // data field on the input stream
  localparam int OP_W      = 3;

  localparam logic [SLOT_W-1:0] NO_SLOT    = '1;
  localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W+1)'(DEPTH);

  localparam int IN_FIELD_W  = 4*SLOT_W + DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = VALUE_W + 4*SLOT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD       = 3'd0,
    OP_SET_ENDS   = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_INS_BEFORE = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_READ       = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LINK1,
    S_LINK2,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] nxt;
    logic [SLOT_W-1:0] prv;
  } link_t;

  // first field in the lowest bits
  typedef struct packed {
    logic [IN_TDATA_W-IN_FIELD_W-1:0] pad;
    logic [COUNT_W-1:0]               count;
    logic [SLOT_W-1:0]                link_prev;
    logic [SLOT_W-1:0]                link_next;
    logic [DATA_W-1:0]                data;
    logic [SLOT_W-1:0]                index;
  } in_data_t;

  typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELD_W-1:0] pad;
    logic [SLOT_W-1:0]                  tail_slot;
    logic [SLOT_W-1:0]                  head_slot;
    logic [SLOT_W-1:0]                  node_prev;
    logic [SLOT_W-1:0]                  node_next;
    logic [VALUE_W-1:0]                 value;
  } out_data_t;

  function automatic logic slot_ok(input logic [SLOT_W-1:0] slot);
    return !slot[SLOT_W-1] && ({1'b0, slot} < SLOT_LIMIT);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot);
    return slot[ADDR_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] data_out(input logic [DATA_BITS-1:0] d);
    return VALUE_W'($signed(d));
  endfunction

endpackage

FILE: hdl/indexed_doubly_linked_list_top.sv
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_top
// Doubly linked list in a slot table: load, set ends, insert, remove, read.
// ----------------------------------------------------------------------------
//  channel  dir  tuser        tdata
//  s_*      in   op           index, data, link_next, link_prev, count
//  m_*      out  status       value, node_next, node_prev, head_slot, tail_slot
//
//  One item at a time, taken only when idle. Load, set ends, read, unused codes,
//  rejected inserts and out-of-range removes go from S_FETCH to S_RESP; inserts at
//  a list end also pass S_LINK1, anchored inserts and removes S_LINK1 and S_LINK2,
//  set by the single write port of the link memory (one link written per cycle).
//  The result is valid in the same cycle as the next item can be taken. A stalled
//  result holds the next item in S_RESP. Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_top
  import idll_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // index, data, link_next, link_prev, count
  input  logic [OP_W-1:0]        s_tuser,   // op
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // value, node_next, node_prev, head, tail
  output logic [0:0]             m_tuser    // status
);

  state_t state, state_next;

  in_data_t in_d;
  op_t                op_q;
  logic [SLOT_W-1:0]  idx_q, lnext_q, lprev_q;
  logic [DATA_W-1:0]  data_q;
  logic [COUNT_W-1:0] cnt_q;

  logic [SLOT_W-1:0]  head, head_next, tail, tail_next;
  logic [COUNT_W-1:0] free_slot, free_slot_next;

  logic [DATA_BITS-1:0] data_mem [DEPTH];
  link_t                link_mem [DEPTH];
  logic [DATA_BITS-1:0] data_rd;
  link_t                link_rd;
  logic [ADDR_W-1:0]    rd_addr, mem_waddr;
  logic                 dmem_we, lmem_we_nxt, lmem_we_prv;
  link_t                lmem_wdata;

  link_t              anc_q;
  logic [SLOT_W-1:0]  n_q;
  logic               res_status, res_status_next;
  logic [VALUE_W-1:0] res_value, res_value_next;
  logic [SLOT_W-1:0]  res_next, res_next_next, res_prev, res_prev_next;

  logic idx_ok, ins_full, is_insert, out_load;
  logic [SLOT_W-1:0] new_slot;

  assign in_d      = in_data_t'(s_tdata);
  assign s_tready  = (state == S_IDLE);
  assign idx_ok    = slot_ok(idx_q);
  assign ins_full  = ({1'b0, free_slot} >= SLOT_LIMIT);
  assign is_insert = (op_q == OP_INS_AFTER) || (op_q == OP_INS_BEFORE);
  assign new_slot  = SLOT_W'(free_slot);
  // the read for an item is launched on the accept edge
  assign rd_addr   = (state == S_IDLE) ? slot_addr(in_d.index) : slot_addr(idx_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NO_SLOT;
      tail      <= NO_SLOT;
      free_slot <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      free_slot <= free_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q    <= op_t'(s_tuser);
      idx_q   <= in_d.index;
      data_q  <= in_d.data;
      lnext_q <= in_d.link_next;
      lprev_q <= in_d.link_prev;
      cnt_q   <= in_d.count;
    end
    if (state == S_FETCH) begin
      anc_q      <= link_rd;
      n_q        <= new_slot;
      res_status <= res_status_next;
      res_value  <= res_value_next;
      res_next   <= res_next_next;
      res_prev   <= res_prev_next;
    end
  end

  // slot table: one write address and one registered read per cycle
  always_ff @(posedge clk) begin
    if (dmem_we)     data_mem[mem_waddr]     <= DATA_BITS'(data_q);
    if (lmem_we_nxt) link_mem[mem_waddr].nxt <= lmem_wdata.nxt;
    if (lmem_we_prv) link_mem[mem_waddr].prv <= lmem_wdata.prv;
    data_rd <= data_mem[rd_addr];
    link_rd <= link_mem[rd_addr];
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    free_slot_next  = free_slot;
    dmem_we         = 1'b0;
    lmem_we_nxt     = 1'b0;
    lmem_we_prv     = 1'b0;
    mem_waddr       = '0;
    lmem_wdata      = '0;
    res_status_next = 1'b0;
    res_value_next  = '0;
    res_next_next   = '0;
    res_prev_next   = '0;
    out_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_FETCH;
      end

      S_FETCH: begin
        state_next = S_RESP;
        case (op_q) inside
          OP_LOAD: begin
            if (idx_ok) begin
              mem_waddr   = slot_addr(idx_q);
              dmem_we     = 1'b1;
              lmem_we_nxt = 1'b1;
              lmem_we_prv = 1'b1;
              lmem_wdata  = '{nxt: lnext_q, prv: lprev_q};
            end
          end
          OP_SET_ENDS: begin
            head_next      = lnext_q;
            tail_next      = lprev_q;
            free_slot_next = cnt_q;
          end
          OP_INS_AFTER, OP_INS_BEFORE: begin
            if (ins_full) begin
              res_status_next = 1'b1;
            end else begin
              // new node first, neighbours in the following cycles
              mem_waddr   = slot_addr(new_slot);
              dmem_we     = 1'b1;
              lmem_we_nxt = 1'b1;
              lmem_we_prv = 1'b1;
              if (op_q == OP_INS_AFTER) begin
                lmem_wdata = idx_ok ? link_t'{nxt: link_rd.nxt, prv: idx_q}
                                    : link_t'{nxt: head, prv: NO_SLOT};
              end else begin
                lmem_wdata = idx_ok ? link_t'{nxt: idx_q, prv: link_rd.prv}
                                    : link_t'{nxt: NO_SLOT, prv: tail};
              end
              free_slot_next = free_slot + COUNT_W'(1);
              res_value_next = {{(VALUE_W-COUNT_W){1'b0}}, free_slot};
              state_next     = S_LINK1;
            end
          end
          OP_REMOVE: begin
            if (idx_ok) begin
              res_value_next = data_out(data_rd);
              state_next     = S_LINK1;
            end
          end
          OP_READ: begin
            if (idx_ok) begin
              res_value_next = data_out(data_rd);
              res_next_next  = link_rd.nxt;
              res_prev_next  = link_rd.prv;
            end
          end
          default: ;
        endcase
      end

      S_LINK1: begin
        state_next = idx_ok ? S_LINK2 : S_RESP;
        case (op_q)
          OP_INS_AFTER: begin
            if (idx_ok) begin
              if (slot_ok(anc_q.nxt)) begin
                mem_waddr      = slot_addr(anc_q.nxt);
                lmem_we_prv    = 1'b1;
                lmem_wdata.prv = n_q;
              end else begin
                tail_next = n_q;
              end
            end else begin
              if (slot_ok(head)) begin
                mem_waddr      = slot_addr(head);
                lmem_we_prv    = 1'b1;
                lmem_wdata.prv = n_q;
              end else begin
                tail_next = n_q;
              end
              head_next = n_q;
            end
          end
          OP_INS_BEFORE: begin
            if (idx_ok) begin
              if (slot_ok(anc_q.prv)) begin
                mem_waddr      = slot_addr(anc_q.prv);
                lmem_we_nxt    = 1'b1;
                lmem_wdata.nxt = n_q;
              end else begin
                head_next = n_q;
              end
            end else begin
              if (slot_ok(tail)) begin
                mem_waddr      = slot_addr(tail);
                lmem_we_nxt    = 1'b1;
                lmem_wdata.nxt = n_q;
              end else begin
                head_next = n_q;
              end
              tail_next = n_q;
            end
          end
          default: begin
            // remove: predecessor takes over our next link
            if (slot_ok(anc_q.prv)) begin
              mem_waddr      = slot_addr(anc_q.prv);
              lmem_we_nxt    = 1'b1;
              lmem_wdata.nxt = anc_q.nxt;
            end else begin
              head_next = anc_q.nxt;
            end
          end
        endcase
      end

      S_LINK2: begin
        state_next = S_RESP;
        case (op_q)
          OP_INS_AFTER: begin
            mem_waddr      = slot_addr(idx_q);
            lmem_we_nxt    = 1'b1;
            lmem_wdata.nxt = n_q;
          end
          OP_INS_BEFORE: begin
            mem_waddr      = slot_addr(idx_q);
            lmem_we_prv    = 1'b1;
            lmem_wdata.prv = n_q;
          end
          default: begin
            if (slot_ok(anc_q.nxt)) begin
              mem_waddr      = slot_addr(anc_q.nxt);
              lmem_we_prv    = 1'b1;
              lmem_wdata.prv = anc_q.prv;
            end else begin
              tail_next = anc_q.prv;
            end
          end
        endcase
      end

      S_RESP: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_data_t'{
        pad:       '0,
        tail_slot: tail,
        head_slot: head,
        node_prev: res_prev,
        node_next: res_next,
        value:     res_value
      };
      m_tuser <= res_status;
    end
  end

  // free slot only moves while an item is being worked on
  a_free_moves_in_fetch: assert property (@(posedge clk) disable iff (rst)
    (free_slot != $past(free_slot)) && !$past(rst) |-> $past(state == S_FETCH))
    else $error("free slot changed outside fetch");

  a_full_insert_dropped: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) && is_insert && ins_full |=> $stable(free_slot) && res_status)
    else $error("insert into full table not rejected");

  a_writes_while_busy: assert property (@(posedge clk) disable iff (rst)
    (dmem_we || lmem_we_nxt || lmem_we_prv) |->
      (state == S_FETCH) || (state == S_LINK1) || (state == S_LINK2))
    else $error("table written while idle or responding");

  a_resp_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) && m_tvalid && !m_tready |=> (state == S_RESP))
    else $error("result overwritten while stalled");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for indexed_doubly_linked_list_top. A short directed
// list build-up covers list ends, anchored inserts, removes, full table and
// unused op codes. Random traffic then works a live list with a few corrupt
// links and stray ops mixed in. Expected results come from a slot-table
// model in the bench and are checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import idll_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 200;
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  typedef logic signed [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  node_next;
    logic [SLOT_W-1:0]  node_prev;
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  tail_slot;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  index;
    logic [DATA_W-1:0]  data;
    logic [SLOT_W-1:0]  link_next;
    logic [SLOT_W-1:0]  link_prev;
    logic [COUNT_W-1:0] count;
    logic [1:0]         phase;
    logic               drain;
    logic               hold;
    list_result_t       res;
  } list_cmd_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // index, data, link_next, link_prev, count
  logic [OP_W-1:0]        s_tuser = '0;   // op
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // value, node_next, node_prev, head, tail
  logic [0:0]             m_tuser;        // status

  indexed_doubly_linked_list_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // shadow of the slot table
  logic [DATA_W-1:0]  slot_data   [DEPTH];
  slot_t              slot_next   [DEPTH];
  slot_t              slot_prev   [DEPTH];
  bit                 slot_written[DEPTH];
  int                 written_q[$];
  int                 live_q[$];
  slot_t              list_head = NO_SLOT;
  slot_t              list_tail = NO_SLOT;
  logic [COUNT_W-1:0] next_free = '0;

  list_cmd_t    op_queue[$];
  list_result_t due_results[$];

  int send_idle_pct [4] = '{0, 47, 0, 28};
  int recv_stall_pct[4] = '{0, 0, 47, 28};

  logic [1:0] gen_phase = '0;
  logic       gen_drain = 1'b0;
  logic       gen_hold  = 1'b0;
  logic [1:0] rx_phase  = '0;

  int errors = 0;
  int acc_count = 0, sent_count = 0, res_count = 0;
  int hold_reqs = 0, hold_done = 0, hold_left = 0;
  int n_insert = 0, n_full = 0, n_remove = 0, n_read = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit is_slot(slot_t s);
    return s >= 0 && int'(s) < DEPTH;
  endfunction

  function automatic bit ref_ok(slot_t s);
    return !is_slot(s) || slot_written[s];
  endfunction

  function automatic void mark_written(slot_t s);
    if (!slot_written[s]) begin
      slot_written[s] = 1'b1;
      written_q.push_back(int'(s));
    end
  endfunction

  // True when the op only touches slots that hold defined contents
  function automatic bit touches_written_only(logic [OP_W-1:0] op, slot_t idx);
    case (op)
      OP_READ:   return ref_ok(idx);
      OP_REMOVE: return !is_slot(idx) ||
                        (slot_written[idx] && ref_ok(slot_prev[idx]) && ref_ok(slot_next[idx]));
      OP_INS_AFTER, OP_INS_BEFORE: begin
        if (int'(next_free) >= DEPTH) return 1'b1;
        if (is_slot(idx))
          return slot_written[idx] &&
                 ref_ok(op == OP_INS_AFTER ? slot_next[idx] : slot_prev[idx]);
        return ref_ok(op == OP_INS_AFTER ? list_head : list_tail);
      end
      default:   return 1'b1;
    endcase
  endfunction

  // Applies one op to the shadow table and returns the result it yields
  function automatic list_result_t list_op_result(logic [OP_W-1:0] op, slot_t idx,
                                                  logic [DATA_W-1:0] dat, slot_t lnx,
                                                  slot_t lpv, logic [COUNT_W-1:0] cnt);
    list_result_t r;
    slot_t n, nb;
    r = '0;
    case (op)
      OP_LOAD: begin
        if (is_slot(idx)) begin
          slot_data[idx] = dat;
          slot_next[idx] = lnx;
          slot_prev[idx] = lpv;
          mark_written(idx);
        end
      end
      OP_SET_ENDS: begin
        list_head = lnx;
        list_tail = lpv;
        next_free = cnt;
      end
      OP_INS_AFTER, OP_INS_BEFORE: begin
        if (int'(next_free) >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          n = slot_t'(next_free);
          slot_data[n] = dat;
          if (op == OP_INS_AFTER) begin
            if (!is_slot(idx)) begin
              slot_next[n] = list_head;
              slot_prev[n] = NO_SLOT;
              if (is_slot(list_head)) slot_prev[list_head] = n;
              else list_tail = n;
              list_head = n;
            end else begin
              // neighbour is read back after the new links, as the block does
              slot_next[n] = slot_next[idx];
              slot_prev[n] = idx;
              nb = slot_next[idx];
              if (is_slot(nb)) slot_prev[nb] = n;
              else list_tail = n;
              slot_next[idx] = n;
            end
          end else begin
            if (!is_slot(idx)) begin
              slot_prev[n] = list_tail;
              slot_next[n] = NO_SLOT;
              if (is_slot(list_tail)) slot_next[list_tail] = n;
              else list_head = n;
              list_tail = n;
            end else begin
              slot_prev[n] = slot_prev[idx];
              slot_next[n] = idx;
              nb = slot_prev[idx];
              if (is_slot(nb)) slot_next[nb] = n;
              else list_head = n;
              slot_prev[idx] = n;
            end
          end
          mark_written(n);
          r.value = VALUE_W'(next_free);
          next_free = next_free + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (is_slot(idx)) begin
          nb = slot_prev[idx];
          if (is_slot(nb)) slot_next[nb] = slot_next[idx];
          else list_head = slot_next[idx];
          nb = slot_next[idx];
          if (is_slot(nb)) slot_prev[nb] = slot_prev[idx];
          else list_tail = slot_prev[idx];
          r.value = slot_data[idx];
        end
      end
      OP_READ: begin
        if (is_slot(idx)) begin
          r.value     = slot_data[idx];
          r.node_next = slot_next[idx];
          r.node_prev = slot_prev[idx];
        end
      end
      default: ;
    endcase
    r.head_slot = list_head;
    r.tail_slot = list_tail;
    return r;
  endfunction

  function automatic void add_cmd(logic [OP_W-1:0] op, slot_t idx, logic [DATA_W-1:0] dat,
                                  slot_t lnx, slot_t lpv, logic [COUNT_W-1:0] cnt);
    list_cmd_t c;
    int hits[$];
    c.op = op;  c.index = idx;  c.data = dat;
    c.link_next = lnx;  c.link_prev = lpv;  c.count = cnt;
    c.phase = gen_phase;  c.drain = gen_drain;  c.hold = gen_hold;
    c.res = list_op_result(op, idx, dat, lnx, lpv, cnt);
    op_queue.push_back(c);
    case (op)
      OP_INS_AFTER, OP_INS_BEFORE: begin
        n_insert++;
        if (c.res.status) n_full++;
        else live_q.push_back(int'(c.res.value));
      end
      OP_REMOVE: begin
        n_remove++;
        hits = live_q.find_index(x) with (x == int'(idx));
        if (hits.size() != 0) live_q.delete(hits[0]);
      end
      OP_READ:     n_read++;
      OP_SET_ENDS: live_q.delete();
      default: ;
    endcase
  endfunction

  function automatic slot_t pick_written();
    return slot_t'(written_q[$urandom_range(0, written_q.size() - 1)]);
  endfunction

  function automatic slot_t pick_live();
    if (live_q.size() == 0) return pick_written();
    return slot_t'(live_q[$urandom_range(0, live_q.size() - 1)]);
  endfunction

  function automatic slot_t pick_negative();
    return slot_t'($urandom_range(1024, 2047));
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // driver: offers the head of op_queue, changes on the falling edge
  always @(negedge clk) begin : drive
    bit offer;
    in_data_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (acc_count != sent_count) begin
        void'(op_queue.pop_front());
        sent_count++;
        offer = 1'b0;
      end
      if (!offer && op_queue.size() != 0) begin
        if (op_queue[0].drain && due_results.size() != 0)
          offer = 1'b0;
        else
          offer = $urandom_range(0, 99) >= send_idle_pct[op_queue[0].phase];
      end
      if (offer) begin
        w = '0;
        w.index     = op_queue[0].index;
        w.data      = op_queue[0].data;
        w.link_next = op_queue[0].link_next;
        w.link_prev = op_queue[0].link_prev;
        w.count     = op_queue[0].count;
        s_tdata <= w;
        s_tuser <= op_queue[0].op;
      end
      s_tvalid <= offer;
    end
  end

  // receiver back-pressure, with the long hold-off counted here
  always @(negedge clk) begin : recv
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= $urandom_range(0, 99) >= recv_stall_pct[rx_phase];
      end
    end
  end

  // monitor: both handshakes sampled on the rising edge
  always @(posedge clk) begin : watch
    out_data_t    o;
    list_result_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(op_queue[0].res);
        rx_phase = op_queue[0].phase;
        if (op_queue[0].hold) hold_reqs++;
        acc_count++;
      end
      if (m_tvalid && m_tready) begin
        o = m_tdata;
        res_count++;
        if (due_results.size() == 0) begin
          $error("result item with nothing expected: tdata 0x%0h", m_tdata);
          errors++;
        end else begin
          e = due_results.pop_front();
          check_field("status",    32'(e.status),    32'(m_tuser[0]));
          check_field("value",     e.value,          o.value);
          check_field("node_next", 32'(e.node_next), 32'(o.node_next));
          check_field("node_prev", 32'(e.node_prev), 32'(o.node_prev));
          check_field("head_slot", 32'(e.head_slot), 32'(o.head_slot));
          check_field("tail_slot", 32'(e.tail_slot), 32'(o.tail_slot));
        end
      end
    end
  end

  initial begin : stimulus
    int r, k, tries;
    logic [OP_W-1:0]    op;
    slot_t              idx, lnx, lpv;
    logic [DATA_W-1:0]  dat;
    logic [COUNT_W-1:0] cnt;

    // directed: build a short list, hit both ends and the middle
    add_cmd(OP_READ,       NO_SLOT, '0, NO_SLOT, NO_SLOT, '0);
    add_cmd(OP_INS_BEFORE, NO_SLOT, 32'h7fff_ffff, '0, '0, '0);   // empty list
    add_cmd(OP_INS_AFTER,  NO_SLOT, 32'h8000_0000, '0, '0, '0);   // new head
    add_cmd(OP_INS_AFTER,  11'sd0,  32'hffff_ffff, '0, '0, '0);   // after tail
    add_cmd(OP_INS_BEFORE, 11'sd1,  32'h0,         '0, '0, '0);   // before head
    add_cmd(OP_INS_AFTER,  11'sd3,  32'h5a5a_5a5a, '0, '0, '0);
    add_cmd(OP_INS_BEFORE, 11'sd2,  32'ha5a5_a5a5, '0, '0, '0);
    add_cmd(OP_INS_AFTER,  slot_t'(11'h400), 32'h1111_1111, '0, '0, '0); // anchor out of range
    add_cmd(OP_INS_BEFORE, -11'sd5, 32'h2222_2222, '0, '0, '0);
    add_cmd(OP_READ,       11'sd4,  '0, '0, '0, '0);
    add_cmd(OP_REMOVE,     11'sd6,  '0, '0, '0, '0);            // head
    add_cmd(OP_REMOVE,     11'sd7,  '0, '0, '0, '0);            // tail
    add_cmd(OP_REMOVE,     11'sd0,  '0, '0, '0, '0);            // middle
    add_cmd(OP_LOAD,       11'sd1023, 32'h1234_5678, NO_SLOT, NO_SLOT, '0);
    add_cmd(OP_LOAD,       11'sd1000, 32'hdead_beef, slot_t'(11'h400), 11'sd1023, '0);
    add_cmd(OP_REMOVE,     11'sd1000, '0, '0, '0, '0);          // slot not in the list
    add_cmd(OP_READ,       11'sd1023, '0, '0, '0, '0);
    add_cmd(OP_LOAD,       -11'sd2, 32'h3333_3333, '0, '0, '0);  // out of range
    add_cmd(OP_REMOVE,     NO_SLOT, '0, '0, '0, '0);
    add_cmd(OP_SPARE6,     11'sd5,  32'h4444_4444, '0, '0, '0);
    add_cmd(OP_SPARE7,     NO_SLOT, '1, NO_SLOT, NO_SLOT, '1);
    add_cmd(OP_SET_ENDS,   '0, '0, NO_SLOT, NO_SLOT, 11'd1023);
    add_cmd(OP_INS_AFTER,  NO_SLOT, 32'h5555_5555, '0, '0, '0);   // takes the last slot
    add_cmd(OP_INS_BEFORE, 11'sd1023, 32'h6666_6666, '0, '0, '0); // table full
    add_cmd(OP_SET_ENDS,   '0, '0, 11'sd0, 11'sd1023, '1);        // free beyond the table
    add_cmd(OP_INS_AFTER,  NO_SLOT, 32'h7777_7777, '0, '0, '0);
    add_cmd(OP_SET_ENDS,   '0, '0, NO_SLOT, NO_SLOT, 11'd8);

    // random: mostly list traffic on live slots, some corrupt links and noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gen_phase = 2'((i / 100) % 4);
      gen_drain = (i == 350) || (i == 600);
      gen_hold  = (i == 200);
      tries = 0;
      do begin
        r   = $urandom_range(0, 99);
        k   = $urandom_range(0, 19);
        dat = $urandom;
        lnx = slot_t'($urandom_range(0, 2047));
        lpv = slot_t'($urandom_range(0, 2047));
        cnt = COUNT_W'($urandom_range(0, 2047));
        if (r < 56) begin
          op  = (r < 28) ? OP_INS_AFTER : OP_INS_BEFORE;
          idx = (k < 16) ? pick_live() : (k < 18) ? NO_SLOT : pick_negative();
        end else if (r < 70) begin
          op  = OP_REMOVE;
          idx = (k < 17) ? pick_live() : (k < 19) ? pick_written() : pick_negative();
        end else if (r < 84) begin
          op  = OP_READ;
          idx = (k < 14) ? pick_live() : (k < 18) ? pick_written() : pick_negative();
        end else if (r < 92) begin
          op  = OP_LOAD;
          idx = (k < 19) ? slot_t'($urandom_range(0, DEPTH - 1)) : pick_negative();
          k   = $urandom_range(0, 9);
          lnx = (k < 4) ? NO_SLOT : (k < 8) ? pick_written() : lnx;
          k   = $urandom_range(0, 9);
          lpv = (k < 4) ? NO_SLOT : (k < 8) ? pick_written() : lpv;
        end else if (r < 97) begin
          op  = OP_SET_ENDS;
          k   = $urandom_range(0, 9);
          if (k < 5) begin
            lnx = NO_SLOT;  lpv = NO_SLOT;  cnt = COUNT_W'($urandom_range(0, 400));
          end else if (k < 8) begin
            lnx = NO_SLOT;  lpv = NO_SLOT;  cnt = COUNT_W'($urandom_range(1010, DEPTH));
          end else begin
            // ends on stored slots, free pointer anywhere
            lnx = pick_written();  lpv = pick_written();
          end
          idx = slot_t'($urandom_range(0, 2047));
        end else begin
          op  = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
          idx = slot_t'($urandom_range(0, 2047));
        end
        tries++;
      end while (!touches_written_only(op, idx) && tries < 8);
      if (!touches_written_only(op, idx)) begin
        op  = OP_READ;
        idx = pick_written();
      end
      add_cmd(op, idx, dat, lnx, lpv, cnt);
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (op_queue.size() == 0 && due_results.size() == 0);
    repeat (20) @(posedge clk);

    $display("Run covered %0d items: %0d inserts (%0d refused on a full table), %0d removes, %0d reads.",
             acc_count, n_insert, n_full, n_remove, n_read);
    $display("%0d results checked over four idling phases, one long output hold-off and two drains.",
             res_count);
    if (errors == 0) begin
      $display("** indexed_doubly_linked_list_top: PASSED **");
    end else begin
      $display("** indexed_doubly_linked_list_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("Timed out with %0d items queued and %0d results outstanding.",
             op_queue.size(), due_results.size());
    $display("** indexed_doubly_linked_list_top: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
hdl/idll_pkg.sv
hdl/indexed_doubly_linked_list_top.sv
tb/testbench.sv
